@@ hw/rtl/bba_pkg.sv @@
// Shared types and codes for the buddy block allocator.
// No dependencies; used by buddy_block_allocator.
package bba_pkg;

    localparam int LVL_W  = 5;   // level numbers 0..31
    localparam int ROW_W  = 32;  // free map bits per memory row
    localparam int BIT_W  = 5;   // bit select within a row
    localparam int TL_W   = 4;
    localparam int SIZE_W = 11;
    localparam int ADDR_W = 10;
    localparam int STAT_W = 2;

    typedef logic [LVL_W-1:0] lvl_t;

    localparam logic       REQ_ALLOC    = 1'b0;
    localparam logic       REQ_FREE     = 1'b1;
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NOSPACE = 2'd1;
    localparam logic [1:0] STAT_ZERO    = 2'd2;

    typedef struct packed {
        logic              req_type;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] block_address;
    } bba_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] granted_address;
        logic [STAT_W-1:0] status;
    } bba_rsp_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN_START,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_SPLIT_RD,
        ST_SPLIT_WR,
        ST_MERGE_RD,
        ST_MERGE_EV,
        ST_SET_RD,
        ST_SET_WR,
        ST_DONE
    } bba_state_t;

endpackage

@@ hw/rtl/bba_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/buddy_block_allocator.sv @@
// Buddy block allocator top level: request sequencer, map index unit, free map.
// Depends on bba_pkg and bba_ram.
//
//  channel | signals                    | direction | carries
//  --------+----------------------------+-----------+---------------------------
//  req     | req_valid req_ready req    | in        | alloc/free transaction
//  rsp     | rsp_valid rsp_ready rsp    | out       | granted address + status
//  cfg     | cfg_valid cfg_ready cfg_data| in       | total_level write
//
// Every map access is a read state plus an evaluate/write state, set by the single
// read port of the free map RAM.
//   alloc: scans the 32-bit map rows from the requested level, stepping up a level
//          when none holds a free block, then splits down to the requested level
//   free : merges with free buddies level by level, at most up to the top level,
//          then sets the bit of the merged block
//   size zero / oversize: go straight to the final state.
// Reset and every cfg write start a clearing pass over all ROWS rows (64 at LEVELS=10)
//   that leaves only the whole-memory block free; req_ready is low meanwhile.
// cfg_ready is high only while idle; a pending cfg write holds off requests.
// A result waiting on rsp_ready holds the sequencer in its final state.
module buddy_block_allocator #(
    parameter int LEVELS = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  bba_pkg::bba_req_t req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output bba_pkg::bba_rsp_t rsp,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [3:0]       cfg_data
);

    import bba_pkg::*;

    localparam int L        = LEVELS;
    localparam int MAP_SIZE = (2 << LEVELS) - 1;
    localparam int ROWS     = (MAP_SIZE + ROW_W - 1) / ROW_W;
    localparam int RW       = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IXW      = RW + BIT_W;           // flat map index width
    localparam logic [L-1:0] ONE_A = L'(1);

    // Flat map index of (level, address): level base + (address >> level).
    function automatic logic [IXW-1:0] map_idx(lvl_t lv, logic [L-1:0] ad);
        logic [31:0] base;
        logic [31:0] off;
        base = (32'd2 << L) - (32'd2 << (L - 32'(lv)));
        off  = 32'(ad) >> lv;
        return IXW'(base + off);
    endfunction

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    bba_state_t           state_reg, state_next;
    logic [TL_W-1:0]      tl_reg, tl_next;
    logic [RW-1:0]        clr_row_reg, clr_row_next;
    lvl_t                 k_reg, k_next;
    lvl_t                 lvl_reg, lvl_next;     // also the split level
    logic [RW-1:0]        r_reg, r_next;         // scan row
    logic [L-1:0]         a_reg, a_next;         // block address
    logic [IXW-1:0]       tgt_reg, tgt_next;     // map bit being touched
    logic [ADDR_W-1:0]    res_addr_reg, res_addr_next;
    logic [STAT_W-1:0]    res_stat_reg, res_stat_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    bba_rsp_t             rsp_reg, rsp_next;

    // ------------------------------------------------------------------
    // Free map RAM
    // ------------------------------------------------------------------
    logic                 ram_we;
    logic [RW-1:0]        ram_waddr;
    logic [ROW_W-1:0]     ram_wdata;
    logic [RW-1:0]        ram_raddr;
    logic [ROW_W-1:0]     ram_rdata;

    bba_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Shared index unit and helpers
    // ------------------------------------------------------------------
    lvl_t                 top;
    lvl_t                 ix_lvl;
    logic [L-1:0]         ix_addr;
    logic [IXW-1:0]       ix_idx;

    assign top = (32'(tl_reg) > L) ? LVL_W'(L) : LVL_W'(tl_reg);
    assign ix_idx = map_idx(ix_lvl, ix_addr);

    // request decode
    logic [SIZE_W-1:0]    size_m1;
    lvl_t                 req_k;
    logic [31:0]          addr32;
    logic [31:0]          free_addr32;

    always_comb
    begin
        size_m1 = req.request_size - SIZE_W'(1);
        req_k   = '0;
        for (int i = 0; i < SIZE_W; i++)
        begin
            if (size_m1[i])
            begin
                req_k = LVL_W'(i + 1);
            end
        end
    end

    assign addr32      = 32'(req.block_address);
    assign free_addr32 = addr32 & ((32'd1 << top) - 32'd1) & ~((32'd1 << req_k) - 32'd1);

    // scan window of the current level
    logic [IXW-1:0]       lo_idx, hi_idx;
    logic [ROW_W-1:0]     row_mask;
    logic [ROW_W-1:0]     row_hits;
    logic                 hit;
    logic [BIT_W-1:0]     hit_bit;
    logic [IXW-1:0]       hit_idx;
    logic [31:0]          hit_off;

    assign lo_idx = ix_idx;
    assign hi_idx = IXW'(32'(ix_idx) + (32'd1 << (top - lvl_reg)) - 32'd1);

    always_comb
    begin
        for (int b = 0; b < ROW_W; b++)
        begin
            row_mask[b] = ({r_reg, BIT_W'(b)} >= lo_idx) && ({r_reg, BIT_W'(b)} <= hi_idx);
        end
        row_hits = ram_rdata & row_mask;
        hit      = |row_hits;
        hit_bit  = '0;
        for (int b = ROW_W - 1; b >= 0; b--)
        begin
            if (row_hits[b])
            begin
                hit_bit = BIT_W'(b);
            end
        end
    end

    assign hit_idx = {r_reg, hit_bit};
    assign hit_off = (32'(hit_idx) - 32'(lo_idx)) << lvl_reg;

    logic [ROW_W-1:0]     tgt_onehot;
    logic                 tgt_is_free;
    logic [IXW-1:0]       top_idx;
    logic [31:0]          res_addr32;

    assign tgt_onehot  = ROW_W'(1) << tgt_reg[BIT_W-1:0];
    assign tgt_is_free = |(ram_rdata & tgt_onehot);
    assign top_idx     = ix_idx;
    assign res_addr32  = 32'(a_reg);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            tl_reg        <= TL_W'(10);
            clr_row_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tl_reg        <= tl_next;
            clr_row_reg   <= clr_row_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        lvl_reg      <= lvl_next;
        r_reg        <= r_next;
        a_reg        <= a_next;
        tgt_reg      <= tgt_next;
        res_addr_reg <= res_addr_next;
        res_stat_reg <= res_stat_next;
        rsp_reg      <= rsp_next;
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        tl_next        = tl_reg;
        clr_row_next   = clr_row_reg;
        k_next         = k_reg;
        lvl_next       = lvl_reg;
        r_next         = r_reg;
        a_next         = a_reg;
        tgt_next       = tgt_reg;
        res_addr_next  = res_addr_reg;
        res_stat_next  = res_stat_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        ix_lvl    = lvl_reg;
        ix_addr   = '0;
        ram_we    = 1'b0;
        ram_waddr = tgt_reg[IXW-1:BIT_W];
        ram_wdata = ram_rdata;
        ram_raddr = tgt_reg[IXW-1:BIT_W];
        req_ready = 1'b0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                // zero the map; the row holding the top block gets its bit
                ix_lvl    = top;
                ram_we    = 1'b1;
                ram_waddr = clr_row_reg;
                ram_wdata = (clr_row_reg == top_idx[IXW-1:BIT_W])
                          ? (ROW_W'(1) << top_idx[BIT_W-1:0]) : '0;
                clr_row_next = clr_row_reg + RW'(1);
                if (clr_row_reg == RW'(ROWS - 1))
                begin
                    clr_row_next = '0;
                    state_next   = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                // a pending cfg write takes precedence over a new request
                req_ready = !cfg_valid;
                if (req_valid && req_ready)
                begin
                    k_next        = req_k;
                    lvl_next      = req_k;
                    res_addr_next = '0;
                    res_stat_next = STAT_OK;
                    if (req.request_size == '0)
                    begin
                        res_stat_next = STAT_ZERO;
                        state_next    = ST_DONE;
                    end
                    else if (req_k > top)
                    begin
                        res_stat_next = STAT_NOSPACE;
                        state_next    = ST_DONE;
                    end
                    else if (req.req_type == REQ_ALLOC)
                    begin
                        state_next = ST_SCAN_START;
                    end
                    else
                    begin
                        a_next     = free_addr32[L-1:0];
                        state_next = ST_MERGE_RD;
                    end
                end
            end

            ST_SCAN_START:
            begin
                r_next     = ix_idx[IXW-1:BIT_W];
                state_next = ST_SCAN_RD;
            end

            ST_SCAN_RD:
            begin
                ram_raddr  = r_reg;
                state_next = ST_SCAN_EV;
            end

            ST_SCAN_EV:
            begin
                if (hit)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = r_reg;
                    ram_wdata  = ram_rdata & ~(ROW_W'(1) << hit_bit);
                    a_next     = hit_off[L-1:0];
                    state_next = ST_SPLIT_RD;
                end
                else if (r_reg == hi_idx[IXW-1:BIT_W])
                begin
                    if (lvl_reg == top)
                    begin
                        res_stat_next = STAT_NOSPACE;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        lvl_next   = lvl_reg + LVL_W'(1);
                        state_next = ST_SCAN_START;
                    end
                end
                else
                begin
                    r_next     = r_reg + RW'(1);
                    state_next = ST_SCAN_RD;
                end
            end

            ST_SPLIT_RD:
            begin
                // mark the upper half free one level down
                ix_lvl  = lvl_reg - LVL_W'(1);
                ix_addr = a_reg + (ONE_A << (lvl_reg - LVL_W'(1)));
                if (lvl_reg == k_reg)
                begin
                    res_addr_next = res_addr32[ADDR_W-1:0];
                    state_next    = ST_DONE;
                end
                else
                begin
                    tgt_next   = ix_idx;
                    ram_raddr  = ix_idx[IXW-1:BIT_W];
                    state_next = ST_SPLIT_WR;
                end
            end

            ST_SPLIT_WR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata | tgt_onehot;
                lvl_next   = lvl_reg - LVL_W'(1);
                state_next = ST_SPLIT_RD;
            end

            ST_MERGE_RD:
            begin
                ix_addr = a_reg ^ (ONE_A << lvl_reg);
                if (lvl_reg >= top)
                begin
                    state_next = ST_SET_RD;
                end
                else
                begin
                    tgt_next   = ix_idx;
                    ram_raddr  = ix_idx[IXW-1:BIT_W];
                    state_next = ST_MERGE_EV;
                end
            end

            ST_MERGE_EV:
            begin
                if (tgt_is_free)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata & ~tgt_onehot;
                    a_next     = a_reg & ~(ONE_A << lvl_reg);
                    lvl_next   = lvl_reg + LVL_W'(1);
                    state_next = ST_MERGE_RD;
                end
                else
                begin
                    state_next = ST_SET_RD;
                end
            end

            ST_SET_RD:
            begin
                ix_addr    = a_reg;
                tgt_next   = ix_idx;
                ram_raddr  = ix_idx[IXW-1:BIT_W];
                state_next = ST_SET_WR;
            end

            ST_SET_WR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata | tgt_onehot;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next           = 1'b1;
                    rsp_next.granted_address = res_addr_reg;
                    rsp_next.status          = res_stat_reg;
                    state_next               = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        // config write reinitializes the map
        if (cfg_valid && cfg_ready)
        begin
            tl_next      = cfg_data;
            clr_row_next = '0;
            state_next   = ST_CLEAR;
        end
    end

    assign cfg_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    // a result only appears from the final state
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("response raised outside final state");

    // merging never climbs above the top level
    a_merge_level: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MERGE_EV) |-> (lvl_reg < top))
        else $error("merge above top level");

    // a config write always triggers the clearing pass
    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> (state_reg == ST_CLEAR && !req_ready))
        else $error("config write did not clear map");

    // split never goes below the requested level
    a_split_level: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SPLIT_WR) |-> (lvl_reg > k_reg))
        else $error("split below requested level");
`endif

endmodule
